// File: src/imubc_pkg.sv
// ============================================================================
// imubc_pkg - shared types and constants of the imu bias calibration core
// field widths, register map, function codes and the sequencer state type
// ============================================================================
package imubc_pkg;

    // geometry of one sample
    localparam int NUM_AXES = 6;
    localparam int AXIS_W   = 3;

    // function codes carried in s_tuser
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CALIB   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // axis order in state: accel x, y, z, then gyro x, y, z
    localparam logic [AXIS_W-1:0] AXIS_FIRST = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_ACC_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_GYR_X = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 3'd5;

    // register and result widths
    localparam int CNT_W   = 16;
    localparam int SCALE_W = 32;
    localparam int HALF_W  = 16;
    localparam int GRAV_W  = 23;
    localparam int BIAS_W  = 25;
    localparam int ACC_W   = 20;
    localparam int GYR_W   = 27;

    // output saturation limits (magnitude of the most negative value)
    localparam int ACC_LIM = 524288;
    localparam int GYR_LIM = 67108864;

    // rounding constant of the step from the product to Q4.16 and Q11.16
    localparam int ROUND_SHIFT = 23;

    // result channel packing
    localparam int M_DATA_W     = 144;
    localparam int M_USER_W     = 2;
    localparam int USER_DONE_IX = 0;
    localparam int USER_SAT_IX  = 1;

    // apb register map
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_CALIB_SAMPLES  = 2'd0;
    localparam logic [1:0] REG_ACCEL_SCALE    = 2'd1;
    localparam logic [1:0] REG_GYRO_SCALE     = 2'd2;
    localparam logic [1:0] REG_GRAVITY_COUNTS = 2'd3;

    // register reset values
    localparam logic [CNT_W-1:0]   RST_CALIB_SAMPLES  = 16'd256;
    localparam logic [SCALE_W-1:0] RST_ACCEL_SCALE    = 32'd261993;
    localparam logic [SCALE_W-1:0] RST_GYRO_SCALE     = 32'd37580964;
    localparam logic [GRAV_W-1:0]  RST_GRAVITY_COUNTS = 23'd4196721;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_FIN,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CLIP,
        ST_EMIT
    } st_t;

endpackage

// File: src/imu_bias_calibrate_scale_core.sv
// ============================================================================
// imu_bias_calibrate_scale_core - six-axis imu bias calibration and scaling
// averages calibration samples into per-axis biases and scales every sample
// ============================================================================
// usage
// - s_ channel: one six-axis raw sample per transaction, function in s_tuser
//   (measure, calibration sample, clear)
// - m_ channel: one result per input transaction; six corrected values, accel
//   Q4.16, rates Q11.16, with calibration-done and saturation flags in m_tuser
// - apb port: calib_samples, accel_scale, gyro_scale and gravity_counts at
//   byte addresses 0, 4, 8 and 12; write only while the core is idle
// - sequence: a measure, clear or ordinary calibration transaction runs the
//   update step, then difference, low and high multiply and clip per axis, then
//   emit; one that completes the average runs the divider on every axis first
// - a new transaction is taken only once the last result is loaded; a single
//   multiplier with a 16-bit scale operand is used twice per axis and the bias
//   mean comes from a bit-serial divider, one quotient bit a cycle, axis after axis
// - s_tready is high only while the sequencer is idle
// - the result sits in an output register; a stalled receiver does not stop
//   the next transaction being accepted, only the hand-over of its result
// - reset: configuration returns to its defaults, sums, biases and the
//   sample count are cleared, no result is pending
// ============================================================================
module imu_bias_calibrate_scale_core #(
    parameter int RAW_BITS = 16,
    parameter int SUM_BITS = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // sample input
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (lowest first)
    input  logic [((imubc_pkg::NUM_AXES*RAW_BITS+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [imubc_pkg::FUNC_W-1:0]               s_tuser,
    // result output
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps
    output logic [imubc_pkg::M_DATA_W-1:0]             m_tdata,
    // calib_done, saturated
    output logic [imubc_pkg::M_USER_W-1:0]             m_tuser,
    // configuration
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [imubc_pkg::ADDR_W-1:0]               paddr,
    input  logic [imubc_pkg::PDATA_W-1:0]              pwdata,
    output logic [imubc_pkg::PDATA_W-1:0]              prdata,
    output logic                                       pready
);
    import imubc_pkg::*;

    // corrected value d = raw * 256 - bias, signed
    localparam int DW    = ((RAW_BITS + 8 > BIAS_W) ? RAW_BITS + 8 : BIAS_W) + 1;
    // product accumulator and rounded magnitude widths
    localparam int PW    = DW + HALF_W + 1;
    localparam int RW    = DW + 9;
    // divider: dividend is |sum| * 256
    localparam int DVD_W = SUM_BITS + 8;
    localparam int DCW   = $clog2(DVD_W);
    localparam int QW    = DVD_W + 2;

    // ------------------------------------------------------------------
    // state and storage
    // ------------------------------------------------------------------
    st_t state_reg, state_next;

    logic [CNT_W-1:0]   calib_samples_reg;
    logic [SCALE_W-1:0] accel_scale_reg;
    logic [SCALE_W-1:0] gyro_scale_reg;
    logic [GRAV_W-1:0]  gravity_reg;

    logic [AXIS_W-1:0]          axis_reg;
    logic [FUNC_W-1:0]          func_reg;
    logic signed [RAW_BITS-1:0] raw_reg  [NUM_AXES];
    logic [SUM_BITS-1:0]        sum_reg  [NUM_AXES];
    logic signed [BIAS_W-1:0]   bias_reg [NUM_AXES];
    logic [CNT_W-1:0]           sample_count_reg;

    // bit-serial divider
    logic [DVD_W-1:0] dvd_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic             div_neg_reg;

    // scaling datapath
    logic [DW-1:0]    mag_reg;
    logic             neg_reg;
    logic [PW-1:0]    acc_reg;
    logic [GYR_W-1:0] res_reg [NUM_AXES];
    logic             sat_reg;
    logic             done_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    // sequencer strobes
    logic in_accept;
    logic out_load;
    logic last_axis;
    logic div_last;
    logic calib_hit;

    logic [CNT_W-1:0] cnt_inc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_samples_reg <= RST_CALIB_SAMPLES;
            accel_scale_reg   <= RST_ACCEL_SCALE;
            gyro_scale_reg    <= RST_GYRO_SCALE;
            gravity_reg       <= RST_GRAVITY_COUNTS;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_CALIB_SAMPLES:  calib_samples_reg <= pwdata[CNT_W-1:0];
                REG_ACCEL_SCALE:    accel_scale_reg   <= pwdata[SCALE_W-1:0];
                REG_GYRO_SCALE:     gyro_scale_reg    <= pwdata[SCALE_W-1:0];
                REG_GRAVITY_COUNTS: gravity_reg       <= pwdata[GRAV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CALIB_SAMPLES:  prdata = PDATA_W'(calib_samples_reg);
            REG_ACCEL_SCALE:    prdata = PDATA_W'(accel_scale_reg);
            REG_GYRO_SCALE:     prdata = PDATA_W'(gyro_scale_reg);
            REG_GRAVITY_COUNTS: prdata = PDATA_W'(gravity_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign cnt_inc   = sample_count_reg + CNT_W'(1);
    assign calib_hit = (cnt_inc >= calib_samples_reg) && (cnt_inc != '0);
    assign last_axis = (axis_reg == AXIS_LAST);
    assign div_last  = (div_cnt_reg == DCW'(DVD_W - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (func_reg == FUNC_CALIB && calib_hit) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIV_LOAD: state_next = ST_DIV_STEP;
            ST_DIV_STEP: begin
                if (div_last) begin
                    state_next = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN: begin
                state_next = last_axis ? ST_DIFF : ST_DIV_LOAD;
            end
            ST_DIFF:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_CLIP;
            ST_CLIP: begin
                state_next = last_axis ? ST_EMIT : ST_DIFF;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // sample capture, tdata slots reordered to accel first
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            func_reg <= s_tuser;
            for (int i = 0; i < NUM_AXES; i++) begin
                raw_reg[i] <= s_tdata[((i < 3) ? (i + 3) : (i - 3)) * RAW_BITS +: RAW_BITS];
            end
        end
    end

    // axis counter, shared by the bias and the scaling passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= AXIS_FIRST;
        end else if (in_accept) begin
            axis_reg <= AXIS_FIRST;
        end else if (state_reg == ST_DIV_FIN || state_reg == ST_CLIP) begin
            axis_reg <= last_axis ? AXIS_FIRST : axis_reg + AXIS_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // bit-serial divider: |sum| * 256 / count, one quotient bit a cycle
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0] sum_sel;
    logic [SUM_BITS-1:0] sum_mag;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_sub;
    logic                rem_ge;

    assign sum_sel = sum_reg[axis_reg];
    assign sum_mag = sum_sel[SUM_BITS-1] ? (SUM_BITS'(0) - sum_sel) : sum_sel;
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, sample_count_reg};
    assign rem_ge  = (rem_sh >= {1'b0, sample_count_reg});

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_DIV_LOAD: begin
                dvd_reg     <= {sum_mag, 8'd0};
                div_neg_reg <= sum_sel[SUM_BITS-1];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV_STEP: begin
                dvd_reg     <= {dvd_reg[DVD_W-2:0], rem_ge};
                rem_reg     <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            default: ;
        endcase
    end

    // signed mean, gravity removed on accel z, clipped to the bias range
    logic signed [QW-1:0]     q_signed;
    logic signed [QW-1:0]     q_grav;
    logic [QW-BIAS_W:0]       q_top;
    logic signed [BIAS_W-1:0] bias_new;

    always_comb begin
        q_signed = div_neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
        q_grav   = q_signed;
        if (axis_reg == AXIS_ACC_Z) begin
            q_grav = q_signed - $signed(QW'(gravity_reg));
        end
        q_top = q_grav[QW-1:BIAS_W-1];
        if ((&q_top) || !(|q_top)) begin
            bias_new = q_grav[BIAS_W-1:0];
        end else if (q_grav[QW-1]) begin
            bias_new = {1'b1, {(BIAS_W-1){1'b0}}};
        end else begin
            bias_new = {1'b0, {(BIAS_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // sums, biases and sample count
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_UPDATE: begin
                    case (func_reg)
                        FUNC_CALIB: begin
                            sample_count_reg <= cnt_inc;
                            for (int i = 0; i < NUM_AXES; i++) begin
                                sum_reg[i] <= sum_reg[i] + SUM_BITS'(raw_reg[i]);
                            end
                        end
                        FUNC_CLEAR: begin
                            sample_count_reg <= '0;
                            for (int i = 0; i < NUM_AXES; i++) begin
                                sum_reg[i]  <= '0;
                                bias_reg[i] <= '0;
                            end
                        end
                        FUNC_MEASURE: ;
                        default: ;
                    endcase
                end
                ST_DIV_FIN: begin
                    bias_reg[axis_reg] <= bias_new;
                    sum_reg[axis_reg]  <= '0;
                    if (last_axis) begin
                        sample_count_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (in_accept) begin
            done_reg <= 1'b0;
        end else if (state_reg == ST_DIV_FIN && last_axis) begin
            done_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // scaling: shared multiplier, low then high half of the scale
    // ------------------------------------------------------------------
    logic signed [DW-1:0] diff_val;
    logic [SCALE_W-1:0]   scale_sel;
    logic [HALF_W-1:0]    mul_b;
    logic [DW+HALF_W-1:0] mul_prod;
    logic [PW-1:0]        acc_lo;
    logic [PW-1:0]        acc_hi;

    assign diff_val  = (DW'(raw_reg[axis_reg]) <<< 8) - DW'(bias_reg[axis_reg]);
    assign scale_sel = (axis_reg < AXIS_GYR_X) ? accel_scale_reg : gyro_scale_reg;
    assign mul_b     = (state_reg == ST_MUL_HI) ? scale_sel[SCALE_W-1:HALF_W]
                                                : scale_sel[HALF_W-1:0];
    assign mul_prod  = mag_reg * mul_b;
    assign acc_lo    = PW'(mul_prod) + (PW'(1) << ROUND_SHIFT);
    assign acc_hi    = PW'(mul_prod) + acc_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_DIFF: begin
                neg_reg <= diff_val[DW-1];
                mag_reg <= diff_val[DW-1] ? (DW'(0) - DW'(diff_val)) : DW'(diff_val);
            end
            ST_MUL_LO: acc_reg <= acc_lo >> HALF_W;
            ST_MUL_HI: acc_reg <= acc_hi >> 8;
            default: ;
        endcase
    end

    // clip to the field range, store sign-extended to the gyro width
    logic [RW-1:0]    r_mag;
    logic [RW-1:0]    r_lim;
    logic [RW-1:0]    r_clip;
    logic             clip_hit;
    logic [GYR_W-1:0] res_val;

    always_comb begin
        r_mag    = acc_reg[RW-1:0];
        r_lim    = (axis_reg < AXIS_GYR_X) ? RW'(ACC_LIM) : RW'(GYR_LIM);
        r_clip   = r_mag;
        clip_hit = 1'b0;
        if (neg_reg) begin
            if (r_mag > r_lim) begin
                r_clip   = r_lim;
                clip_hit = 1'b1;
            end
        end else if (r_mag > r_lim - RW'(1)) begin
            r_clip   = r_lim - RW'(1);
            clip_hit = 1'b1;
        end
        res_val = neg_reg ? (GYR_W'(0) - r_clip[GYR_W-1:0]) : r_clip[GYR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLIP) begin
            res_reg[axis_reg] <= res_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (in_accept) begin
            sat_reg <= 1'b0;
        end else if (state_reg == ST_CLIP && clip_hit) begin
            sat_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [M_DATA_W-1:0] out_data;
    logic [M_USER_W-1:0] out_user;

    always_comb begin
        out_data = '0;
        for (int i = 0; i < 3; i++) begin
            out_data[i*ACC_W +: ACC_W]           = res_reg[i][ACC_W-1:0];
            out_data[3*ACC_W + i*GYR_W +: GYR_W] = res_reg[i+3];
        end
        out_user               = '0;
        out_user[USER_DONE_IX] = done_reg;
        out_user[USER_SAT_IX]  = sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_starts_update: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_UPDATE)
        else $error("accepted transaction did not start the update step");

    a_done_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && done_reg) |-> sample_count_reg == '0)
        else $error("completed calibration left a nonzero sample count");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_STEP |-> rem_reg < sample_count_reg)
        else $error("divider remainder not below the sample count");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result load did not present a result and return to idle");

endmodule
